/* rtl/qoi_rgb_pixel_encoder_top_macros.svh */
// Assertion macros shared by the QOI RGB pixel encoder RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef QOI_RGB_PIXEL_ENCODER_TOP_MACROS_SVH
`define QOI_RGB_PIXEL_ENCODER_TOP_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define QRE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds through reset
`define QRE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/qre_pkg.sv */
// Package for the QOI RGB pixel encoder: transaction types, opcodes and the hash.
// No dependencies.
`timescale 1ns / 1ps

package qre_pkg;

  // Seen table geometry
  localparam int INDEX_SIZE = 64;
  localparam int IDX_W      = $clog2(INDEX_SIZE);

  // Opcodes
  localparam logic [7:0] OP_RGB  = 8'hFE;
  localparam logic [7:0] OP_DIFF = 8'h40;
  localparam logic [7:0] OP_LUMA = 8'h80;
  localparam logic [7:0] OP_RUN  = 8'hC0;

  // Longest run held before it is emitted
  localparam logic [5:0] RUN_LIMIT = 6'd62;

  // Alpha is fixed at 255, so its hash term is a constant
  localparam logic [12:0] HASH_BIAS = 13'(255 * 11);

  // Most bytes one pixel can cause: a run flush and an RGB literal
  localparam int MAX_BYTES = 5;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_of_pixel;
  } code_t;

  // Outcome of coding one pixel
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;    // bytes[0] goes out first
    logic [CNT_W-1:0]          count;
    logic [5:0]                run_nxt;
    logic                      pix_new;  // pixel differs from the previous one
    logic                      tab_wr;   // table entry gets this pixel
  } coder_res_t;

  // Table position: (3r + 5g + 7b + 11*255) mod INDEX_SIZE
  function automatic logic [IDX_W-1:0] qre_hash(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [12:0] sum;
    sum = 13'(r) * 13'd3 + 13'(g) * 13'd5 + 13'(b) * 13'd7 + HASH_BIAS;
    return sum[IDX_W-1:0];
  endfunction

endpackage

/* rtl/qre_coder.sv */
// Combinational opcode selection for one pixel (RUN, INDEX, DIFF, LUMA, RGB).
// Depends on qre_pkg.
`timescale 1ns / 1ps

module qre_coder
  import qre_pkg::*;
(
  input  pixel_t           pix,
  input  logic [23:0]      prev,
  input  logic [5:0]       run,
  input  logic [IDX_W-1:0] hash,
  input  logic [23:0]      entry,
  output coder_res_t       res
);

  logic [23:0]      packed_pix;
  logic             same;
  logic [5:0]       run_inc;
  logic [7:0]       dr, dg, db, rr, rb;
  logic [7:0]       dr2, dg2, db2, dg32, rr8, rb8;
  logic             diff_ok, luma_ok;
  logic [3:0][7:0]  cb;
  logic [CNT_W-1:0] ccnt;

  // Wrapping differences; range tests become unsigned after the bias
  always_comb begin
    packed_pix = {pix.red, pix.green, pix.blue};
    same       = (packed_pix == prev);
    run_inc    = run + 6'd1;
    dr         = pix.red   - prev[23:16];
    dg         = pix.green - prev[15:8];
    db         = pix.blue  - prev[7:0];
    rr         = dr - dg;
    rb         = db - dg;
    dr2        = dr + 8'd2;
    dg2        = dg + 8'd2;
    db2        = db + 8'd2;
    dg32       = dg + 8'd32;
    rr8        = rr + 8'd8;
    rb8        = rb + 8'd8;
    diff_ok    = (dr2 < 8'd4) && (dg2 < 8'd4) && (db2 < 8'd4);
    luma_ok    = (dg32 < 8'd64) && (rr8 < 8'd16) && (rb8 < 8'd16);
  end

  // Bytes for one pixel: a run, or the code of a pixel that differs from the previous one
  always_comb begin
    cb          = '0;
    ccnt        = '0;
    res         = '0;
    res.pix_new = !same;
    if (entry == packed_pix) begin
      cb[0] = {{(8-IDX_W){1'b0}}, hash};
      ccnt  = CNT_W'(1);
    end else begin
      res.tab_wr = 1'b1;
      if (diff_ok) begin
        cb[0] = OP_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
        ccnt  = CNT_W'(1);
      end else if (luma_ok) begin
        cb[0] = OP_LUMA | {2'b00, dg32[5:0]};
        cb[1] = {rr8[3:0], rb8[3:0]};
        ccnt  = CNT_W'(2);
      end else begin
        cb[0] = OP_RGB;
        cb[1] = pix.red;
        cb[2] = pix.green;
        cb[3] = pix.blue;
        ccnt  = CNT_W'(4);
      end
    end

    if (same) begin
      // Repeat: extend the run, emit it at the limit or at frame end
      res.tab_wr = 1'b0;
      if (run_inc == RUN_LIMIT) begin
        res.bytes[0] = OP_RUN | {2'b00, RUN_LIMIT - 6'd1};
        res.count    = CNT_W'(1);
        res.run_nxt  = '0;
      end else begin
        res.run_nxt = run_inc;
        if (pix.last_pixel) begin
          res.bytes[0] = OP_RUN | {2'b00, run};
          res.count    = CNT_W'(1);
        end
      end
    end else if (run != 6'd0) begin
      // Pending run goes out ahead of the new pixel
      res.bytes[0]   = OP_RUN | {2'b00, run - 6'd1};
      res.bytes[4:1] = cb;
      res.count      = ccnt + CNT_W'(1);
    end else begin
      res.bytes[3:0] = cb;
      res.count      = ccnt;
    end
  end

endmodule

/* rtl/qoi_rgb_pixel_encoder_top.sv */
// Top level of the QOI RGB pixel encoder: input register, seen table, byte burst output.
// Depends on qre_pkg, qre_coder and qoi_rgb_pixel_encoder_top_macros.svh.
`timescale 1ns / 1ps
`include "qoi_rgb_pixel_encoder_top_macros.svh"

// A pixel accepted into the input register shows its first byte once the burst is loaded.
// Throughput: one pixel per cycle while each pixel gives at most one byte and out_stall
// is low; the output moves one byte per unstalled cycle, and a burst holds input till done.
// Reset (synchronous, rst_n low) clears the run, previous pixel and the 64 table
// valid bits; the last pixel of a frame does the same after coding.

module qoi_rgb_pixel_encoder_top
  import qre_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  pixel_t in_data,
  output logic   out_valid,
  input  logic   out_stall,
  output code_t  out_data
);

  // Seen table memory and its valid bits
  logic [23:0]           tab_mem [INDEX_SIZE];
  logic [23:0]           rd_r;
  logic [INDEX_SIZE-1:0] tab_vld_r, tab_vld_nxt;

  // Bypass of the latest table write
  logic                  fwd_en_r;
  logic [IDX_W-1:0]      fwd_pos_r;
  logic [23:0]           fwd_data_r;

  // Input register
  logic                  s1_vld_r, s1_vld_nxt;
  pixel_t                s1_pix_r;
  logic [IDX_W-1:0]      s1_hash_r;

  // Coding state
  logic [23:0]           prev_r;
  logic [5:0]            run_r;

  // Output burst
  logic [MAX_BYTES-1:0][7:0] burst_r;
  logic [CNT_W-1:0]          burst_cnt_r, burst_cnt_nxt;

  logic                  in_acc, out_acc, fire;
  logic [IDX_W-1:0]      hash_in;
  logic [23:0]           entry;
  coder_res_t            res;

  // Handshake
  assign out_acc  = out_valid && !out_stall;
  assign fire     = s1_vld_r && ((burst_cnt_r == '0) ||
                                 ((burst_cnt_r == CNT_W'(1)) && out_acc));
  assign in_stall = s1_vld_r && !fire;
  assign in_acc   = in_valid && !in_stall;
  assign hash_in  = qre_hash(in_data.red, in_data.green, in_data.blue);

  assign out_valid              = (burst_cnt_r != '0);
  assign out_data.code_byte     = burst_r[0];
  assign out_data.last_of_pixel = (burst_cnt_r == CNT_W'(1));

  // Table entry seen by the registered pixel; unwritten entries read as black
  always_comb begin
    if (!tab_vld_r[s1_hash_r]) begin
      entry = '0;
    end else if (fwd_en_r && (fwd_pos_r == s1_hash_r)) begin
      entry = fwd_data_r;
    end else begin
      entry = rd_r;
    end
  end

  qre_coder u_coder (
    .pix   (s1_pix_r),
    .prev  (prev_r),
    .run   (run_r),
    .hash  (s1_hash_r),
    .entry (entry),
    .res   (res)
  );

  // Table memory: read at the incoming pixel's hash, write on a miss
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= tab_mem[hash_in];
    end
    if (fire && res.tab_wr) begin
      tab_mem[s1_hash_r] <= {s1_pix_r.red, s1_pix_r.green, s1_pix_r.blue};
    end
  end

  // Next-state logic for control registers
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (fire) begin
      s1_vld_nxt = 1'b0;
    end

    tab_vld_nxt = tab_vld_r;
    if (fire) begin
      if (s1_pix_r.last_pixel) begin
        tab_vld_nxt = '0;
      end else if (res.tab_wr) begin
        tab_vld_nxt[s1_hash_r] = 1'b1;
      end
    end

    burst_cnt_nxt = burst_cnt_r;
    if (fire && (res.count != '0)) begin
      burst_cnt_nxt = res.count;
    end else if (out_acc) begin
      burst_cnt_nxt = burst_cnt_r - CNT_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      tab_vld_r   <= '0;
      burst_cnt_r <= '0;
      fwd_en_r    <= 1'b0;
      prev_r      <= '0;
      run_r       <= '0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      tab_vld_r   <= tab_vld_nxt;
      burst_cnt_r <= burst_cnt_nxt;
      if (fire) begin
        if (s1_pix_r.last_pixel) begin
          fwd_en_r <= 1'b0;
          prev_r   <= '0;
          run_r    <= '0;
        end else begin
          if (res.tab_wr) begin
            fwd_en_r <= 1'b1;
          end
          if (res.pix_new) begin
            prev_r <= {s1_pix_r.red, s1_pix_r.green, s1_pix_r.blue};
          end
          run_r <= res.run_nxt;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_data;
      s1_hash_r <= hash_in;
    end
    if (fire && res.tab_wr) begin
      fwd_pos_r  <= s1_hash_r;
      fwd_data_r <= {s1_pix_r.red, s1_pix_r.green, s1_pix_r.blue};
    end
    if (fire && (res.count != '0)) begin
      burst_r <= res.bytes;
    end else if (out_acc) begin
      burst_r <= burst_r >> 8;
    end
  end

  // Checks
  `QRE_ASSERT(a_burst_bound, burst_cnt_r <= CNT_W'(MAX_BYTES), "burst count overflow")
  `QRE_ASSERT(a_run_bound, run_r < RUN_LIMIT, "run count reached the limit")
  `QRE_ASSERT(a_accept_loads, in_acc |=> s1_vld_r, "accepted pixel lost")
  `QRE_ASSERT(a_frame_clear, (fire && s1_pix_r.last_pixel) |=> (run_r == '0 && tab_vld_r == '0 && prev_r == '0), "state not cleared at frame end")
  `QRE_ASSERT_RST(a_reset_idle, !rst_n |=> (burst_cnt_r == '0 && !s1_vld_r), "not idle after reset")

endmodule

/* tb/sv/tb_qoi_rgb_pixel_encoder_top.sv */
// Self-checking testbench for qoi_rgb_pixel_encoder_top: pixel transactions in, opcode bytes out.
// Depends on qre_pkg and the encoder RTL; expected bytes come from an in-bench encoder model.
`timescale 1ns / 1ps

module tb_qoi_rgb_pixel_encoder_top;
  import qre_pkg::*;

  localparam int HOLD_CYCLES = 200;  // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 16;  // settling time after the last byte

  logic   clk;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  pixel_t in_data = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  code_t  out_data;

  qoi_rgb_pixel_encoder_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Encoder model state
  logic [7:0]  enc_prev_r, enc_prev_g, enc_prev_b;
  logic [5:0]  enc_run;
  logic [23:0] enc_seen [INDEX_SIZE];
  code_t       expected_codes [$];

  // Stimulus state
  int          send_idle_pct;
  int          recv_idle_pct;
  int          mismatches = 0;
  int          hold_start = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic [23:0] tx_rgb;             // pixel the block will compare the next one against
  logic [23:0] recent_rgb [$];     // candidates for table hits

  function automatic void clear_encoder_state();
    enc_prev_r = '0;
    enc_prev_g = '0;
    enc_prev_b = '0;
    enc_run    = '0;
    foreach (enc_seen[i]) enc_seen[i] = '0;
  endfunction

  // Work out the opcode bytes for one accepted pixel and queue them
  function automatic void predict_codes(pixel_t p);
    logic [7:0]        out_bytes [$];
    logic [23:0]       px_word;
    logic signed [7:0] d8;
    logic [6:0]        run_next;
    int                dr, dg, db, rr, rb, pos;
    px_word = {p.red, p.green, p.blue};
    if (px_word == {enc_prev_r, enc_prev_g, enc_prev_b}) begin
      // repeat: extend the run, emit at the limit
      run_next = enc_run + 7'd1;
      if (run_next == {1'b0, RUN_LIMIT}) begin
        out_bytes.push_back(OP_RUN | 8'(run_next - 7'd1));
        run_next = '0;
      end
      enc_run = run_next[5:0];
    end else begin
      if (enc_run != 0) begin
        out_bytes.push_back(OP_RUN | 8'(enc_run - 6'd1));
        enc_run = '0;
      end
      pos = (3 * p.red + 5 * p.green + 7 * p.blue + 255 * 11) % INDEX_SIZE;
      if (enc_seen[pos] == px_word) begin
        out_bytes.push_back(8'(pos));
      end else begin
        enc_seen[pos] = px_word;
        d8 = p.red - enc_prev_r;
        dr = d8;
        d8 = p.green - enc_prev_g;
        dg = d8;
        d8 = p.blue - enc_prev_b;
        db = d8;
        if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
          out_bytes.push_back(OP_DIFF | 8'((dr + 2) << 4 | (dg + 2) << 2 | (db + 2)));
        end else begin
          d8 = 8'(dr - dg);
          rr = d8;
          d8 = 8'(db - dg);
          rb = d8;
          if (rr >= -8 && rr <= 7 && dg >= -32 && dg <= 31 && rb >= -8 && rb <= 7) begin
            out_bytes.push_back(OP_LUMA | 8'(dg + 32));
            out_bytes.push_back(8'((rr + 8) << 4 | (rb + 8)));
          end else begin
            out_bytes.push_back(OP_RGB);
            out_bytes.push_back(p.red);
            out_bytes.push_back(p.green);
            out_bytes.push_back(p.blue);
          end
        end
      end
      enc_prev_r = p.red;
      enc_prev_g = p.green;
      enc_prev_b = p.blue;
    end
    // end of frame: flush the run, then everything back to zero
    if (p.last_pixel) begin
      if (enc_run != 0) out_bytes.push_back(OP_RUN | 8'(enc_run - 6'd1));
      clear_encoder_state();
    end
    foreach (out_bytes[i])
      expected_codes.push_back(code_t'{code_byte: out_bytes[i],
                                       last_of_pixel: (i == out_bytes.size() - 1)});
  endfunction

  function automatic pixel_t px(int r, int g, int b, int l);
    return '{red: 8'(r), green: 8'(g), blue: 8'(b), last_pixel: 1'(l)};
  endfunction

  // Random pixel, biased towards runs, small deltas, luma deltas, table hits and black
  function automatic pixel_t make_pixel(int frame_end_pct);
    pixel_t      p;
    logic [23:0] rgb;
    int          pick, dg;
    pick = $urandom_range(0, 99);
    rgb  = {8'($urandom), 8'($urandom), 8'($urandom)};
    if (pick < 30) begin
      rgb = tx_rgb;
    end else if (pick < 50) begin
      rgb[23:16] = 8'(tx_rgb[23:16] + $urandom_range(0, 4) - 2);
      rgb[15:8]  = 8'(tx_rgb[15:8] + $urandom_range(0, 4) - 2);
      rgb[7:0]   = 8'(tx_rgb[7:0] + $urandom_range(0, 4) - 2);
    end else if (pick < 70) begin
      // just inside and just outside the luma ranges
      dg = int'($urandom_range(0, 67)) - 34;
      rgb[15:8]  = 8'(tx_rgb[15:8] + dg);
      rgb[23:16] = 8'(tx_rgb[23:16] + dg + int'($urandom_range(0, 17)) - 9);
      rgb[7:0]   = 8'(tx_rgb[7:0] + dg + int'($urandom_range(0, 17)) - 9);
    end else if (pick < 85 && recent_rgb.size() != 0) begin
      rgb = recent_rgb[$urandom_range(0, recent_rgb.size() - 1)];
    end else if (pick >= 95) begin
      rgb = '0;
    end
    p = px(int'(rgb[23:16]), int'(rgb[15:8]), int'(rgb[7:0]),
           int'($urandom_range(0, 99) < frame_end_pct));
    recent_rgb.push_back(rgb);
    if (recent_rgb.size() > 8) void'(recent_rgb.pop_front());
    tx_rgb = p.last_pixel ? 24'd0 : rgb;
    return p;
  endfunction

  // Offer one pixel, with random idle cycles first; returns at the accepting edge
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    predict_codes(p);
  endtask

  // Sender pauses until every queued byte has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_codes.size() != 0);
  endtask

  // Receiver stall and byte checking
  always @(posedge clk) begin
    code_t want;
    out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_codes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected byte: expected none, got %h (last %b)",
                 $time, out_data.code_byte, out_data.last_of_pixel);
      end else begin
        want = expected_codes.pop_front();
        if (out_data.code_byte !== want.code_byte ||
            out_data.last_of_pixel !== want.last_of_pixel) begin
          mismatches++;
          $display("%0t: byte mismatch: expected %h (last %b), got %h (last %b)", $time,
                   want.code_byte, want.last_of_pixel, out_data.code_byte,
                   out_data.last_of_pixel);
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_start != hold_seen) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_start;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Every opcode, range edges, empty table entries, black first pixel, frame ends
  task automatic test_opcodes();
    pixel_t seq [$];
    seq = '{px(0, 0, 0, 0), px(0, 0, 0, 0), px(255, 255, 255, 0), px(0, 0, 0, 0),
            px(1, 1, 1, 0), px(255, 255, 255, 0), px(254, 253, 253, 0),
            px(36, 28, 20, 0), px(252, 252, 251, 0), px(254, 252, 251, 0),
            px(30, 28, 27, 0), px(0, 255, 128, 0), px(0, 255, 128, 0),
            px(0, 255, 128, 0), px(0, 255, 128, 0), px(1, 255, 128, 0),
            px(1, 255, 128, 1), px(255, 255, 255, 0), px(0, 0, 0, 0), px(0, 0, 0, 1),
            px(0, 0, 0, 1), px(170, 85, 15, 1), px(85, 170, 240, 0),
            px(85, 170, 240, 1)};
    foreach (seq[i]) send_pixel(seq[i]);
    tx_rgb = '0;
  endtask

  // A run that reaches the limit and goes past it, then a shorter one that ends a frame
  task automatic test_run_limit();
    int     lens [2] = '{63, 30};
    pixel_t p;
    foreach (lens[k]) begin
      p = px($urandom_range(1, 255), $urandom, $urandom, 0);
      send_pixel(p);
      for (int n = 1; n <= lens[k]; n++) begin
        p.last_pixel = (k == 1 && n == lens[k]);
        send_pixel(p);
      end
    end
    tx_rgb = '0;
  endtask

  task automatic test_random_frames(input int count);
    repeat (count) send_pixel(make_pixel(4));
  endtask

  // Hold the output off while literals keep coming, so the input stalls
  task automatic test_backpressure_fill();
    pixel_t p;
    hold_start <= hold_start + 1;
    repeat (30) begin
      p = px($urandom, $urandom, $urandom, 0);
      tx_rgb = {p.red, p.green, p.blue};
      send_pixel(p);
    end
  endtask

  // Sender stops until everything is out, then carries on
  task automatic test_drain_pause();
    repeat (12) send_pixel(make_pixel(4));
    wait_drained();
    repeat (12) send_pixel(make_pixel(4));
  endtask

  initial begin
    clear_encoder_state();
    tx_rgb        = '0;
    send_idle_pct = 24;
    recv_idle_pct = 46;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_opcodes();
    test_run_limit();
    test_random_frames(19);

    send_idle_pct = 46;
    recv_idle_pct = 24;
    test_random_frames(19);
    test_drain_pause();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(19);
    test_backpressure_fill();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
